FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is low
`define QPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked while reset is low
`define QPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication that is also checked during reset
`define QPH_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/qph_pkg.sv
package qph_pkg;

    localparam int KEY_W = 31;
    localparam int MODE_W = 2;
    localparam int CNT_OUT_W = 12;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [1:0] status_t;
    typedef logic [CNT_OUT_W-1:0] count_t;

    // operation codes
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_SEARCH = 2'd1;
    localparam mode_t MODE_DELETE = 2'd2;

    // slot status codes
    localparam status_t SLOT_EMPTY = 2'd0;
    localparam status_t SLOT_OCCUPIED = 2'd1;
    localparam status_t SLOT_REMOVED = 2'd2;

    // reported probe count saturates here
    localparam count_t COUNT_MAX = 12'd4095;

    // status from the probe engine to the top level
    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

FILE: rtl/qph_fifo.sv
module qph_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/qph_front.sv
module qph_front #(
    parameter int TABLE_SIZE = 4093
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  qph_pkg::mode_t             in_mode,
    input  qph_pkg::key_t              in_key,
    output logic                       out_push,
    input  logic                       out_full,
    output qph_pkg::mode_t             out_mode,
    output qph_pkg::key_t              out_key,
    output logic [$clog2(TABLE_SIZE)-1:0] out_home
);
    import qph_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int SH = KEY_W + IDX_W;
    localparam int PROD_W = 2 * KEY_W + 1;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / TABLE_SIZE;
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];
    localparam key_t T_K = KEY_W'(TABLE_SIZE);

    logic              en;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    mode_t             mode1_reg;
    mode_t             mode2_reg;
    mode_t             mode3_reg;
    key_t              key1_reg;
    key_t              key2_reg;
    key_t              key3_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [PROD_W-1:0] prod2_next;
    key_t              quot2;
    key_t              qt3_reg;
    key_t              qt3_next;
    key_t              diff3;
    key_t              rem3;

    // the whole pipe stalls while its last word waits on a full queue
    assign en = !(v3_reg && out_full);
    assign in_ready = en;

    // key times reciprocal, then estimated quotient times table size
    assign prod2_next = PROD_W'(key1_reg) * PROD_W'(RECIP);
    assign quot2 = KEY_W'(prod2_reg >> SH);
    assign qt3_next = quot2 * T_K;

    // remainder from the estimate is below twice the table size
    assign diff3 = key3_reg - qt3_reg;
    assign rem3 = (diff3 >= T_K) ? (diff3 - T_K) : diff3;

    assign out_push = v3_reg && !out_full;
    assign out_mode = mode3_reg;
    assign out_key = key3_reg;
    assign out_home = rem3[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= in_mode;
            key1_reg <= in_key;
            mode2_reg <= mode1_reg;
            key2_reg <= key1_reg;
            prod2_reg <= prod2_next;
            mode3_reg <= mode2_reg;
            key3_reg <= key2_reg;
            qt3_reg <= qt3_next;
        end
    end

endmodule

FILE: rtl/qph_back.sv
module qph_back #(
    parameter int TABLE_SIZE = 4093
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  qph_pkg::mode_t                q_mode,
    input  qph_pkg::key_t                 q_key,
    input  logic [$clog2(TABLE_SIZE)-1:0] q_home,
    output qph_pkg::back_stat_t           stat,
    input  logic                          res_pop,
    output logic                          res_valid,
    output logic                          res_ok,
    output qph_pkg::count_t               res_count
);
    import qph_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam logic [IDX_W:0] T_S = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] T_C = CNT_W'(TABLE_SIZE);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    status_t          status_mem [TABLE_SIZE];
    key_t             key_mem [TABLE_SIZE];

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    mode_t            mode_reg;
    mode_t            mode_next;
    key_t             key_reg;
    key_t             key_next;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;
    logic [IDX_W-1:0] inc_reg;
    logic [IDX_W-1:0] inc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             ok_reg;
    logic             ok_next;
    logic [IDX_W-1:0] clr_reg;
    logic [IDX_W-1:0] clr_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             res_ok_reg;
    logic             res_ok_next;
    count_t           res_count_reg;
    count_t           res_count_next;

    status_t          st_rd_reg;
    key_t             key_rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    status_t          st_wdata;
    logic             key_we;

    logic [IDX_W:0]   slot_sum;
    logic [IDX_W:0]   slot_adv;
    logic [IDX_W:0]   inc_sum;
    logic [IDX_W:0]   inc_adv;
    logic [31:0]      cnt_wide;
    count_t           cnt_sat;
    logic             is_op;
    logic             key_hit;

    // next probe slot: add the step, then the step grows by two
    assign slot_sum = {1'b0, slot_reg} + {1'b0, inc_reg};
    assign slot_adv = (slot_sum >= T_S) ? (slot_sum - T_S) : slot_sum;
    assign inc_sum = {1'b0, inc_reg} + (IDX_W + 1)'(2);
    assign inc_adv = (inc_sum >= T_S) ? (inc_sum - T_S) : inc_sum;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign cnt_wide = 32'(cnt_reg);
    assign cnt_sat = (cnt_wide > 32'(COUNT_MAX)) ? COUNT_MAX : cnt_wide[CNT_OUT_W-1:0];

    assign is_op = (q_mode == MODE_INSERT) || (q_mode == MODE_SEARCH)
                   || (q_mode == MODE_DELETE);
    assign key_hit = (st_rd_reg == SLOT_OCCUPIED) && (key_rd_reg == key_reg);

    assign stat.clearing = (state_reg == S_CLEAR);
    assign res_valid = res_valid_reg;
    assign res_ok = res_ok_reg;
    assign res_count = res_count_reg;

    // probe sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        key_next = key_reg;
        slot_next = slot_reg;
        inc_next = inc_reg;
        cnt_next = cnt_reg;
        ok_next = ok_reg;
        clr_next = clr_reg;
        res_valid_next = res_valid_reg;
        res_ok_next = res_ok_reg;
        res_count_next = res_count_reg;
        rd_addr = slot_reg;
        st_we = 1'b0;
        st_waddr = slot_reg;
        st_wdata = SLOT_OCCUPIED;
        key_we = 1'b0;
        q_pop = 1'b0;

        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                st_we = 1'b1;
                st_waddr = clr_reg;
                st_wdata = SLOT_EMPTY;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = q_home;
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    mode_next = q_mode;
                    key_next = q_key;
                    slot_next = q_home;
                    inc_next = IDX_W'(1);
                    cnt_next = '0;
                    ok_next = 1'b0;
                    state_next = is_op ? S_EVAL : S_HOLD;
                end
            end
            S_EVAL:
            begin
                rd_addr = slot_adv[IDX_W-1:0];
                cnt_next = cnt_inc;
                state_next = S_HOLD;
                if (mode_reg == MODE_INSERT)
                begin
                    if (st_rd_reg == SLOT_EMPTY || st_rd_reg == SLOT_REMOVED)
                    begin
                        st_we = 1'b1;
                        key_we = 1'b1;
                        ok_next = 1'b1;
                    end
                    else if (cnt_inc != T_C)
                    begin
                        state_next = S_EVAL;
                    end
                end
                else if (st_rd_reg == SLOT_EMPTY)
                begin
                    ok_next = 1'b0;
                end
                else if (key_hit)
                begin
                    ok_next = 1'b1;
                    if (mode_reg == MODE_DELETE)
                    begin
                        st_we = 1'b1;
                        st_wdata = SLOT_REMOVED;
                    end
                end
                else if (cnt_inc != T_C)
                begin
                    state_next = S_EVAL;
                end
                if (state_next == S_EVAL)
                begin
                    slot_next = slot_adv[IDX_W-1:0];
                    inc_next = inc_adv[IDX_W-1:0];
                end
            end
            S_HOLD:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    res_valid_next = 1'b1;
                    res_ok_next = ok_reg;
                    res_count_next = cnt_sat;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // operation payload
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        key_reg <= key_next;
        slot_reg <= slot_next;
        inc_reg <= inc_next;
        cnt_reg <= cnt_next;
        ok_reg <= ok_next;
        res_ok_reg <= res_ok_next;
        res_count_reg <= res_count_next;
    end

    // slot status memory
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            status_mem[st_waddr] <= st_wdata;
        end
        st_rd_reg <= status_mem[rd_addr];
    end

    // slot key memory
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[slot_reg] <= key_reg;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

endmodule

FILE: rtl/quadratic_probe_hash_table.sv
// path from accepted word to result: the three front stages, the queue, then the probe
// sequencer (idle, one evaluation per slot probed, hold) and the result registers
// the front pipe and queue can take new words while the sequencer probes; the sequencer
// handles one operation at a time, with one read of the slot status and key memories per probe;
// the home slot is hashed in a 3-stage front pipe that runs ahead of the probes
// reset: asynchronous; afterwards a clearing pass empties every slot while full stays high
module quadratic_probe_hash_table #(
    parameter int TABLE_SIZE = 4093
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  qph_pkg::mode_t  mode,
    input  qph_pkg::key_t   key,
    output logic            empty,
    input  logic            pop,
    output logic            ok,
    output qph_pkg::count_t probe_count
);
    import qph_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int ENT_W = MODE_W + KEY_W + IDX_W;

    logic             front_ready;
    logic             front_push;
    mode_t            front_mode;
    key_t             front_key;
    logic [IDX_W-1:0] front_home;
    logic             fifo_full;
    logic             fifo_empty;
    logic             fifo_pop;
    logic [ENT_W-1:0] fifo_out;
    back_stat_t       back_stat;
    logic             res_valid;

    // no word is taken while the slot memory is being cleared
    assign full = !front_ready || back_stat.clearing;
    assign empty = !res_valid;

    qph_front #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(push && !back_stat.clearing),
        .in_ready(front_ready),
        .in_mode(mode),
        .in_key(key),
        .out_push(front_push),
        .out_full(fifo_full),
        .out_mode(front_mode),
        .out_key(front_key),
        .out_home(front_home)
    );

    qph_fifo #(
        .WIDTH(ENT_W)
    ) u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(front_push),
        .push_data({front_mode, front_key, front_home}),
        .full(fifo_full),
        .pop(fifo_pop),
        .pop_data(fifo_out),
        .empty(fifo_empty)
    );

    qph_back #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(!fifo_empty),
        .q_pop(fifo_pop),
        .q_mode(fifo_out[ENT_W-1 -: MODE_W]),
        .q_key(fifo_out[IDX_W +: KEY_W]),
        .q_home(fifo_out[IDX_W-1:0]),
        .stat(back_stat),
        .res_pop(pop),
        .res_valid(res_valid),
        .res_ok(ok),
        .res_count(probe_count)
    );

endmodule

FILE: rtl/qph_checker.sv
`include "assert_macros.svh"

module qph_checker #(
    parameter int TABLE_SIZE = 4093
) (
    input logic            clk,
    input logic            rst_n,
    input logic            full,
    input logic            empty,
    input logic            pop,
    input logic            ok,
    input qph_pkg::count_t probe_count
);
    import qph_pkg::*;

    localparam count_t PC_MAX = (TABLE_SIZE > 4095) ? COUNT_MAX : CNT_OUT_W'(TABLE_SIZE);

    // held in reset: nothing taken, nothing offered
    `QPH_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, full && empty)

    // a waiting result holds until taken
    `QPH_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(ok) && $stable(probe_count))

    // probe count never beyond the table or the saturation point
    `QPH_ASSERT_IMPLY(a_count_bound, clk, rst_n, !empty, probe_count <= PC_MAX)

    // a success always examined at least one slot
    `QPH_ASSERT_IMPLY(a_ok_probed, clk, rst_n, !empty && ok, probe_count != 12'd0)

endmodule

bind quadratic_probe_hash_table qph_checker #(
    .TABLE_SIZE(TABLE_SIZE)
) u_qph_checker (
    .clk(clk),
    .rst_n(rst_n),
    .full(full),
    .empty(empty),
    .pop(pop),
    .ok(ok),
    .probe_count(probe_count)
);
